FILE: hw/rtl/jcs_pkg.sv
`timescale 1ns / 1ps

package jcs_pkg;

    // character codes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;

    // scan mode codes
    localparam logic [2:0] MODE_NORMAL     = 3'd0;
    localparam logic [2:0] MODE_STR        = 3'd1;
    localparam logic [2:0] MODE_STR_ESC    = 3'd2;
    localparam logic [2:0] MODE_SLASH      = 3'd3;
    localparam logic [2:0] MODE_LINE       = 3'd4;
    localparam logic [2:0] MODE_BLOCK      = 3'd5;
    localparam logic [2:0] MODE_BLOCK_STAR = 3'd6;

    // result queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_stream;
    } t_result;

    // what one input beat produces
    typedef struct packed {
        logic [2:0] next_mode;
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_scan;

endpackage

FILE: hw/rtl/jcs_scan.sv
`timescale 1ns / 1ps

module jcs_scan (
    input  logic [2:0]    i_mode,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output jcs_pkg::t_scan o_scan
);
    import jcs_pkg::*;

    logic [2:0] mode;
    logic [1:0] cnt;
    t_result    r0;
    t_result    r1;

    always_comb begin
        mode = i_mode;
        cnt  = 2'd0;
        r0   = '0;
        r1   = '0;

        unique case (i_mode)
            MODE_STR: begin
                r0  = '{out_byte: i_byte, has_byte: 1'b1, end_of_stream: 1'b0};
                cnt = 2'd1;
                if (i_byte == CH_BSLASH) begin
                    mode = MODE_STR_ESC;
                end else if (i_byte == CH_QUOTE) begin
                    mode = MODE_NORMAL;
                end
            end
            MODE_STR_ESC: begin
                r0   = '{out_byte: i_byte, has_byte: 1'b1, end_of_stream: 1'b0};
                cnt  = 2'd1;
                mode = MODE_STR;
            end
            MODE_SLASH: begin
                if (i_byte == CH_SLASH) begin
                    mode = MODE_LINE;
                end else if (i_byte == CH_STAR) begin
                    mode = MODE_BLOCK;
                end else begin
                    // held slash released, then the byte as plain text
                    r0  = '{out_byte: CH_SLASH, has_byte: 1'b1, end_of_stream: 1'b0};
                    cnt = 2'd1;
                    if (i_byte == CH_SLASH && !i_last) begin
                        mode = MODE_SLASH;
                    end else begin
                        r1   = '{out_byte: i_byte, has_byte: 1'b1, end_of_stream: 1'b0};
                        cnt  = 2'd2;
                        mode = (i_byte == CH_QUOTE) ? MODE_STR : MODE_NORMAL;
                    end
                end
            end
            MODE_LINE: begin
                if (i_byte == CH_NL) begin
                    r0   = '{out_byte: i_byte, has_byte: 1'b1, end_of_stream: 1'b0};
                    cnt  = 2'd1;
                    mode = MODE_NORMAL;
                end
            end
            MODE_BLOCK: begin
                if (i_byte == CH_STAR) begin
                    mode = MODE_BLOCK_STAR;
                end
            end
            MODE_BLOCK_STAR: begin
                if (i_byte == CH_SLASH) begin
                    mode = MODE_NORMAL;
                end else if (i_byte != CH_STAR) begin
                    mode = MODE_BLOCK;
                end
            end
            default: begin
                // normal text, also the unused code
                if (i_byte == CH_SLASH && !i_last) begin
                    mode = MODE_SLASH;
                end else begin
                    r0   = '{out_byte: i_byte, has_byte: 1'b1, end_of_stream: 1'b0};
                    cnt  = 2'd1;
                    mode = (i_byte == CH_QUOTE) ? MODE_STR : MODE_NORMAL;
                end
            end
        endcase

        // end of stream marking
        if (i_last) begin
            if (cnt == 2'd2) begin
                r1.end_of_stream = 1'b1;
            end else if (cnt == 2'd1) begin
                r0.end_of_stream = 1'b1;
            end else begin
                r0  = '{out_byte: 8'd0, has_byte: 1'b0, end_of_stream: 1'b1};
                cnt = 2'd1;
            end
            mode = MODE_NORMAL;
        end
    end

    assign o_scan = '{next_mode: mode, count: cnt, res0: r0, res1: r1};

endmodule

FILE: hw/rtl/jsonc_comment_stripper.sv
`timescale 1ns / 1ps

// jsonc comment stripper
// input channel: i_valid / o_ready with i_in_byte and i_last_byte, one text
// byte per beat; i_last_byte marks the final byte of a stream.
// output channel: o_valid / i_ready with o_out_byte, o_has_byte and
// o_end_of_stream. comment bytes produce no beat; a slash is held until the
// next byte shows whether it opens a comment, so one input beat gives zero,
// one or two output beats. the last input byte always gives a beat with
// o_end_of_stream set, with o_has_byte low if no data came with it.
// a result is registered into the result queue when its input beat is
// accepted, and is offered once the results queued ahead of it have left.
// throughput: one input beat per cycle while the output side takes a beat
// per cycle and o_ready stays high; the four-entry result queue sets this,
// and o_ready is high while at least two entries are free.
// a stalled receiver lets the queue take three or four entries, then o_ready
// stays low until it drains; nothing is lost.
// reset (synchronous, active low) empties the queue and returns the scanner
// to normal text mode.
module jsonc_comment_stripper (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_end_of_stream
);
    import jcs_pkg::*;

    logic [2:0]   r_mode;
    t_scan        scan;
    t_result      r_queue [QDEPTH];
    logic [QAW-1:0] r_head;
    logic [QAW-1:0] r_tail;
    logic [QAW:0]   r_count;
    logic [QAW:0]   n_count;
    logic           in_acc;
    logic           out_acc;
    logic [QAW-1:0] tail_p1;

    assign o_ready = (r_count <= (QAW+1)'(QDEPTH - 2));
    assign o_valid = (r_count != '0);
    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign tail_p1 = r_tail + 1'b1;

    jcs_scan u_scan (
        .i_mode (r_mode),
        .i_byte (i_in_byte),
        .i_last (i_last_byte),
        .o_scan (scan)
    );

    // scan mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
        end else if (in_acc) begin
            r_mode <= scan.next_mode;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (scan.count != 2'd0) begin
                r_queue[r_tail] <= scan.res0;
            end
            if (scan.count == 2'd2) begin
                r_queue[tail_p1] <= scan.res1;
            end
        end
    end

    // queue occupancy
    always_comb begin
        n_count = r_count;
        if (out_acc) begin
            n_count = n_count - 1'b1;
        end
        if (in_acc) begin
            n_count = n_count + (QAW+1)'(scan.count);
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (out_acc) begin
                r_head <= r_head + 1'b1;
            end
            if (in_acc) begin
                r_tail <= r_tail + QAW'(scan.count);
            end
        end
    end

    assign o_out_byte      = r_queue[r_head].out_byte;
    assign o_has_byte      = r_queue[r_head].has_byte;
    assign o_end_of_stream = r_queue[r_head].end_of_stream;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW+1)'(QDEPTH))
        else $error("result queue overflow");

    a_last_resets_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_byte) |=> (r_mode == MODE_NORMAL))
        else $error("mode not normal after last byte");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_byte) |=> o_valid)
        else $error("last byte produced no result");

    a_ptr_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (QAW'(r_head + QAW'(r_count)) == r_tail))
        else $error("queue pointers disagree with count");
`endif

endmodule
